// File: src/diff_drive_pose_tracking_pi_top_assert.svh
// Assertion macros used by the checker file of the tracking controller.
`ifndef DIFF_DRIVE_POSE_TRACKING_PI_TOP_ASSERT_SVH
`define DIFF_DRIVE_POSE_TRACKING_PI_TOP_ASSERT_SVH

// Clocked check, suspended while reset is high.
`define DDPT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DDPT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/ddpt_pkg.sv
// Shared types, constants and arithmetic helpers of the tracking controller.
package ddpt_pkg;

   localparam int DEFAULT_CORDIC_STEPS = 16;
   localparam int ITER_COUNT = 32;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [65:0] INT32_MAX_W = 66'sd2147483647;
   localparam logic signed [65:0] INT32_MIN_W = -66'sd2147483648;
   localparam logic signed [65:0] TWO_POW_31_W = 66'sd2147483648;

   localparam logic [15:0] RST_HEADING_GAIN_NOW = 16'd922;
   localparam logic [15:0] RST_HEADING_GAIN_PREV = 16'd1024;
   localparam logic [15:0] RST_DISTANCE_GAIN_NOW = 16'd768;
   localparam logic [15:0] RST_DISTANCE_GAIN_PREV = 16'd768;
   localparam logic [30:0] RST_HALF_TRACK_WIDTH = 31'd65536;
   localparam logic [30:0] RST_INV_RADIUS = 31'd65536;

   typedef struct packed {
      logic operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [19:0] heading;
   } ddpt_req_type;

   typedef struct packed {
      logic signed [31:0] left_wheel_speed;
      logic signed [31:0] right_wheel_speed;
      logic signed [31:0] forward_speed;
      logic signed [31:0] turn_rate;
   } ddpt_rsp_type;

   typedef struct packed {
      logic signed [15:0] heading_gain_now;
      logic signed [15:0] heading_gain_prev;
      logic signed [15:0] distance_gain_now;
      logic signed [15:0] distance_gain_prev;
      logic [30:0] half_track_width;
      logic [30:0] inv_radius_left;
      logic [30:0] inv_radius_right;
   } ddpt_cfg_type;

   typedef enum logic [2:0] {
      REG_HEADING_GAIN_NOW = 3'd0,
      REG_HEADING_GAIN_PREV = 3'd1,
      REG_DISTANCE_GAIN_NOW = 3'd2,
      REG_DISTANCE_GAIN_PREV = 3'd3,
      REG_HALF_TRACK_WIDTH = 3'd4,
      REG_INV_RADIUS_LEFT = 3'd5,
      REG_INV_RADIUS_RIGHT = 3'd6
   } ddpt_reg_type;

   typedef enum logic [4:0] {
      CMD_IDLE, CMD_FB, CMD_REF, CMD_SQX, CMD_SQY, CMD_SUM, CMD_ITER, CMD_FIN,
      CMD_MAD, CMD_MBD, CMD_VUP, CMD_MBH, CMD_WUP, CMD_MT, CMD_TRD,
      CMD_LHI, CMD_LLO, CMD_LSUM, CMD_RLO, CMD_RSUM, CMD_PUSH
   } ddpt_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_ITER, ST_FIN,
      ST_MAD, ST_MBD, ST_VUP, ST_MBH, ST_WUP, ST_MT, ST_TRD,
      ST_LHI, ST_LLO, ST_LSUM, ST_RLO, ST_RSUM, ST_OUT
   } ddpt_state_type;

   typedef struct packed {
      ddpt_op_type op;
      logic [4:0] idx;
   } ddpt_cmd_type;

   typedef struct packed {
      logic out_free;
   } ddpt_status_type;

   // CORDIC arctangent of 2^-i in Q30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0: v = 30'd843314857;
         5'd1: v = 30'd497837829;
         5'd2: v = 30'd263043837;
         5'd3: v = 30'd133525159;
         5'd4: v = 30'd67021687;
         5'd5: v = 30'd33543516;
         5'd6: v = 30'd16775851;
         5'd7: v = 30'd8388437;
         5'd8: v = 30'd4194283;
         5'd9: v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return $signed({4'b0, v});
   endfunction

   // divide by 2^s, round to nearest, ties away from zero
   function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                    input int unsigned s);
      logic signed [65:0] half;
      logic signed [65:0] mag;
      half = 66'sd1 <<< (s - 1);
      if (v < 0) begin
         mag = -v;
         return -((mag + half) >>> s);
      end
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > INT32_MAX_W) return 32'sh7fffffff;
      if (v < INT32_MIN_W) return 32'sh80000000;
      return v[31:0];
   endfunction

   // apply sign to a wheel magnitude product, clamping to 32 bits
   function automatic logic signed [31:0] wheel_fin(input logic signed [65:0] p,
                                                    input logic neg);
      logic signed [65:0] r;
      r = (p > TWO_POW_31_W) ? TWO_POW_31_W : p;
      if (neg) return sat32(-r);
      return sat32(r);
   endfunction

endpackage

// File: src/ddpt_csr.sv
// Configuration register file with APB-style access.
module ddpt_csr import ddpt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output ddpt_cfg_type cfg
);

   ddpt_cfg_type cfg_ff, cfg_in;
   ddpt_reg_type reg_sel;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   assign reg_sel = ddpt_reg_type'(paddr[4:2]);
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_HEADING_GAIN_NOW: cfg_in.heading_gain_now = pwdata[15:0];
            REG_HEADING_GAIN_PREV: cfg_in.heading_gain_prev = pwdata[15:0];
            REG_DISTANCE_GAIN_NOW: cfg_in.distance_gain_now = pwdata[15:0];
            REG_DISTANCE_GAIN_PREV: cfg_in.distance_gain_prev = pwdata[15:0];
            REG_HALF_TRACK_WIDTH: cfg_in.half_track_width = pwdata[30:0];
            REG_INV_RADIUS_LEFT: cfg_in.inv_radius_left = pwdata[30:0];
            REG_INV_RADIUS_RIGHT: cfg_in.inv_radius_right = pwdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_HEADING_GAIN_NOW: prdata = 32'(cfg_ff.heading_gain_now);
         REG_HEADING_GAIN_PREV: prdata = 32'(cfg_ff.heading_gain_prev);
         REG_DISTANCE_GAIN_NOW: prdata = 32'(cfg_ff.distance_gain_now);
         REG_DISTANCE_GAIN_PREV: prdata = 32'(cfg_ff.distance_gain_prev);
         REG_HALF_TRACK_WIDTH: prdata = {1'b0, cfg_ff.half_track_width};
         REG_INV_RADIUS_LEFT: prdata = {1'b0, cfg_ff.inv_radius_left};
         REG_INV_RADIUS_RIGHT: prdata = {1'b0, cfg_ff.inv_radius_right};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heading_gain_now <= RST_HEADING_GAIN_NOW;
         cfg_ff.heading_gain_prev <= RST_HEADING_GAIN_PREV;
         cfg_ff.distance_gain_now <= RST_DISTANCE_GAIN_NOW;
         cfg_ff.distance_gain_prev <= RST_DISTANCE_GAIN_PREV;
         cfg_ff.half_track_width <= RST_HALF_TRACK_WIDTH;
         cfg_ff.inv_radius_left <= RST_INV_RADIUS;
         cfg_ff.inv_radius_right <= RST_INV_RADIUS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/ddpt_ctrl.sv
// Sequencer that steps the datapath through one tracking update.
module ddpt_ctrl import ddpt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_operation,
   output logic req_stall,
   input  ddpt_status_type status,
   output ddpt_cmd_type cmd
);

   ddpt_state_type state_ff, state_in;
   logic [4:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_operation) state_in = ST_SQX;
         ST_SQX: state_in = ST_SQY;
         ST_SQY: state_in = ST_SUM;
         ST_SUM: state_in = ST_ITER;
         ST_ITER: if (idx_ff == 5'(ITER_COUNT - 1)) state_in = ST_FIN;
         ST_FIN: state_in = ST_MAD;
         ST_MAD: state_in = ST_MBD;
         ST_MBD: state_in = ST_VUP;
         ST_VUP: state_in = ST_MBH;
         ST_MBH: state_in = ST_WUP;
         ST_WUP: state_in = ST_MT;
         ST_MT: state_in = ST_TRD;
         ST_TRD: state_in = ST_LHI;
         ST_LHI: state_in = ST_LLO;
         ST_LLO: state_in = ST_LSUM;
         ST_LSUM: state_in = ST_RLO;
         ST_RLO: state_in = ST_RSUM;
         ST_RSUM: state_in = ST_OUT;
         ST_OUT: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (state_ff == ST_SUM) idx_in = 5'd0;
      else if (state_ff == ST_ITER) idx_in = idx_ff + 5'd1;
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!req_valid) cmd.op = CMD_IDLE;
            else if (req_operation) cmd.op = CMD_REF;
            else cmd.op = CMD_FB;
         end
         ST_SQX: cmd.op = CMD_SQX;
         ST_SQY: cmd.op = CMD_SQY;
         ST_SUM: cmd.op = CMD_SUM;
         ST_ITER: cmd.op = CMD_ITER;
         ST_FIN: cmd.op = CMD_FIN;
         ST_MAD: cmd.op = CMD_MAD;
         ST_MBD: cmd.op = CMD_MBD;
         ST_VUP: cmd.op = CMD_VUP;
         ST_MBH: cmd.op = CMD_MBH;
         ST_WUP: cmd.op = CMD_WUP;
         ST_MT: cmd.op = CMD_MT;
         ST_TRD: cmd.op = CMD_TRD;
         ST_LHI: cmd.op = CMD_LHI;
         ST_LLO: cmd.op = CMD_LLO;
         ST_LSUM: cmd.op = CMD_LSUM;
         ST_RLO: cmd.op = CMD_RLO;
         ST_RSUM: cmd.op = CMD_RSUM;
         ST_OUT: cmd.op = status.out_free ? CMD_PUSH : CMD_IDLE;
         default: cmd.op = CMD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// File: src/ddpt_dp.sv
// Datapath: CORDIC atan2, digit-serial square root, shared multiplier, output register.
module ddpt_dp import ddpt_pkg::*; #(
   parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
) (
   input  logic clock,
   input  logic reset,
   input  ddpt_cmd_type cmd,
   input  ddpt_cfg_type cfg,
   input  ddpt_req_type req_payload,
   input  logic rsp_stall,
   output ddpt_status_type status,
   output logic rsp_valid,
   output ddpt_rsp_type rsp_payload
);

   logic signed [31:0] meas_x_ff, meas_y_ff;
   logic signed [19:0] meas_heading_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [32:0] ax, ay;
   logic big;
   logic big_ff, zero_ff;
   logic signed [51:0] cx_ff, cy_ff, x0, y0, sx, sy;
   logic signed [33:0] cz_ff, ang;
   logic [61:0] sq_ff;
   logic [63:0] rad_ff;
   logic [35:0] rem_ff, rem_sh, trial;
   logic [31:0] root_ff;
   logic signed [21:0] he_ff, lhe_ff;
   logic signed [31:0] de_ff, lde_ff, lfs_ff, lt_ff;
   logic signed [65:0] acc_ff, mul_ff, mul_p, zr, t;
   logic signed [32:0] mul_a, mul_b;
   logic signed [48:0] lin_l_ff, lin_r_ff;
   logic [47:0] mag_l, mag_r;
   logic signed [31:0] left_ff, right_ff;
   logic [32:0] de_round;
   logic step_on;
   logic rsp_valid_ff;
   ddpt_rsp_type rsp_ff;

   assign ax = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign big = ax[32] | ax[31] | ay[32] | ay[31];
   assign x0 = {{3{dx_ff[32]}}, dx_ff, 16'b0};
   assign y0 = {{3{dy_ff[32]}}, dy_ff, 16'b0};
   assign mag_l = lin_l_ff[48] ? 48'(-lin_l_ff) : lin_l_ff[47:0];
   assign mag_r = lin_r_ff[48] ? 48'(-lin_r_ff) : lin_r_ff[47:0];

   // one root digit per iteration, plus one CORDIC vectoring step while idx < CORDIC_STEPS
   assign sx = cx_ff >>> cmd.idx;
   assign sy = cy_ff >>> cmd.idx;
   assign ang = atan_q30(cmd.idx);
   assign step_on = (int'({27'b0, cmd.idx}) < CORDIC_STEPS);
   assign rem_sh = {rem_ff[33:0], rad_ff[63:62]};
   assign trial = {2'b0, root_ff, 2'b01};

   assign zr = zero_ff ? 66'sd0 : rnd_shift(66'(cz_ff), 14);
   assign de_round = {1'b0, root_ff} + {32'b0, (rem_ff > {4'b0, root_ff})};
   assign t = rnd_shift(mul_ff, 16);

   // shared multiplier, operands chosen by the current command
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         CMD_SQX: begin
            mul_a = {2'b0, ax[30:0]};
            mul_b = {2'b0, ax[30:0]};
         end
         CMD_SQY: begin
            mul_a = {2'b0, ay[30:0]};
            mul_b = {2'b0, ay[30:0]};
         end
         CMD_MAD: begin
            mul_a = 33'(cfg.distance_gain_now);
            mul_b = 33'(de_ff);
         end
         CMD_MBD: begin
            mul_a = 33'(cfg.distance_gain_prev);
            mul_b = 33'(lde_ff);
         end
         CMD_VUP: begin
            mul_a = 33'(cfg.heading_gain_now);
            mul_b = 33'(he_ff);
         end
         CMD_MBH: begin
            mul_a = 33'(cfg.heading_gain_prev);
            mul_b = 33'(lhe_ff);
         end
         CMD_MT: begin
            mul_a = {2'b0, cfg.half_track_width};
            mul_b = 33'(lt_ff);
         end
         CMD_LHI: begin
            mul_a = {1'b0, mag_l[47:16]};
            mul_b = {2'b0, cfg.inv_radius_left};
         end
         CMD_LLO: begin
            mul_a = {17'b0, mag_l[15:0]};
            mul_b = {2'b0, cfg.inv_radius_left};
         end
         CMD_LSUM: begin
            mul_a = {1'b0, mag_r[47:16]};
            mul_b = {2'b0, cfg.inv_radius_right};
         end
         CMD_RLO: begin
            mul_a = {17'b0, mag_r[15:0]};
            mul_b = {2'b0, cfg.inv_radius_right};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      mul_ff <= mul_p;
      case (cmd.op)
         CMD_REF: begin
            dx_ff <= 33'(req_payload.pos_x) - 33'(meas_x_ff);
            dy_ff <= 33'(req_payload.pos_y) - 33'(meas_y_ff);
         end
         CMD_SQX: begin
            big_ff <= big;
            zero_ff <= (dx_ff == 33'sd0) && (dy_ff == 33'sd0);
            // fold the left half plane into the right one
            if (dx_ff < 0) begin
               if (dy_ff >= 0) begin
                  cx_ff <= y0;
                  cy_ff <= -x0;
                  cz_ff <= HALF_PI_Q30;
               end else begin
                  cx_ff <= -y0;
                  cy_ff <= x0;
                  cz_ff <= -HALF_PI_Q30;
               end
            end else begin
               cx_ff <= x0;
               cy_ff <= y0;
               cz_ff <= 34'sd0;
            end
         end
         CMD_SQY: sq_ff <= mul_ff[61:0];
         CMD_SUM: begin
            rad_ff <= {2'b0, sq_ff} + 64'(mul_ff[61:0]);
            rem_ff <= '0;
            root_ff <= '0;
         end
         CMD_ITER: begin
            if (step_on) begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + sy;
                  cy_ff <= cy_ff - sx;
                  cz_ff <= cz_ff + ang;
               end else begin
                  cx_ff <= cx_ff - sy;
                  cy_ff <= cy_ff + sx;
                  cz_ff <= cz_ff - ang;
               end
            end
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff <= rem_sh - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         CMD_FIN: begin
            he_ff <= 22'(zr - 66'(meas_heading_ff));
            if (big_ff || de_round[32] || de_round[31]) de_ff <= 32'sh7fffffff;
            else de_ff <= $signed(de_round[31:0]);
         end
         CMD_MBD: acc_ff <= mul_ff;
         CMD_MBH: acc_ff <= mul_ff;
         CMD_LLO: acc_ff <= mul_ff;
         CMD_RLO: acc_ff <= mul_ff;
         CMD_TRD: begin
            lin_l_ff <= 49'(66'(lfs_ff) - t);
            lin_r_ff <= 49'(66'(lfs_ff) + t);
         end
         CMD_LSUM: left_ff <= wheel_fin(acc_ff + ((mul_ff + 66'sd32768) >>> 16),
                                        lin_l_ff[48]);
         CMD_RSUM: right_ff <= wheel_fin(acc_ff + ((mul_ff + 66'sd32768) >>> 16),
                                         lin_r_ff[48]);
         CMD_PUSH: begin
            rsp_ff.left_wheel_speed <= left_ff;
            rsp_ff.right_wheel_speed <= right_ff;
            rsp_ff.forward_speed <= lfs_ff;
            rsp_ff.turn_rate <= lt_ff;
         end
         default: begin
         end
      endcase
   end

   // controller state of the loop, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         meas_x_ff <= '0;
         meas_y_ff <= '0;
         meas_heading_ff <= '0;
         lhe_ff <= '0;
         lde_ff <= '0;
         lfs_ff <= '0;
         lt_ff <= '0;
      end else begin
         case (cmd.op)
            CMD_FB: begin
               meas_x_ff <= req_payload.pos_x;
               meas_y_ff <= req_payload.pos_y;
               meas_heading_ff <= req_payload.heading;
            end
            CMD_VUP: lfs_ff <= sat32(66'(lfs_ff) + rnd_shift(acc_ff - mul_ff, 8));
            CMD_WUP: begin
               lt_ff <= sat32(66'(lt_ff) + rnd_shift(acc_ff - mul_ff, 8));
               lhe_ff <= he_ff;
               lde_ff <= de_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.op == CMD_PUSH) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: src/diff_drive_pose_tracking_pi_top.sv
// Top level of the differential-drive point-tracking PI controller.
//
// Input channel (req_*): one transaction per pose item. operation = 0 stores
// the measured pose (x, y, heading) and yields no result; the block takes it
// without stalling and is ready again at once. operation = 1 is a reference
// point and yields exactly one result transaction on rsp_*.
// After a reference is accepted, the block squares the offset (states SQX,
// SQY, SUM), runs 32 iterations in which the CORDIC atan2 (in its first
// CORDIC_STEPS iterations) and the root digit loop run side by side (the
// root loop sets the count), finishes both errors, works through the single
// shared multiplier for the two PI updates and the wheel speeds, and loads
// the output register; rsp_valid rises once that register is loaded.
// req_stall stays high during that work and until the result is pushed.
// Results sit in an output register: the next item is accepted while a result
// still waits, and only the final push waits if the receiver still stalls.
// While rsp_valid and rsp_stall are both high, rsp_valid and rsp_payload hold.
// Reset clears the stored pose, the PI history and the output valid, and
// loads the configuration defaults; there is no clearing pass.
// The user is to write configuration (psel/penable/pwrite, pready always high)
// only while the block is idle; the block itself does not enforce this.
module diff_drive_pose_tracking_pi_top import ddpt_pkg::*; #(
   parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ddpt_req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ddpt_rsp_type rsp_payload,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   ddpt_cfg_type cfg;
   ddpt_cmd_type cmd;
   ddpt_status_type status;

   // register file
   ddpt_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   // sequencer: accepts items and issues one command per cycle
   ddpt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_payload.operation),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   // arithmetic and the result register
   ddpt_dp #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .cfg(cfg),
      .req_payload(req_payload),
      .rsp_stall(rsp_stall),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

// File: src/ddpt_checker.sv
// Port-level checks of the tracking controller and their binding.
`include "diff_drive_pose_tracking_pi_top_assert.svh"

module ddpt_checker import ddpt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input ddpt_req_type req_payload,
   input logic rsp_valid,
   input logic rsp_stall,
   input ddpt_rsp_type rsp_payload
);

   `DDPT_ASSERT_ALWAYS(a_reset_no_rsp, reset |=> !rsp_valid, "result valid after reset")
   `DDPT_ASSERT(a_ref_busy, (req_valid && !req_stall && req_payload.operation) |=> req_stall, "reference did not start work")
   `DDPT_ASSERT(a_fb_free, (req_valid && !req_stall && !req_payload.operation) |=> !req_stall, "feedback stalled the input")
   `DDPT_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)), "stalled result changed")

endmodule

bind diff_drive_pose_tracking_pi_top ddpt_checker u_chk (.*);
